@@ design/path_string_hash_macros.svh @@
`ifndef PATH_STRING_HASH_MACROS_SVH
`define PATH_STRING_HASH_MACROS_SVH

// same-cycle implication
`define PSH_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PSH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/psh_pkg.sv @@
package psh_pkg;

    localparam int MaxWords = 64;
    localparam int CountW   = $clog2(MaxWords + 1);

    localparam logic [31:0] FixWord0  = 32'h9BE74448;
    localparam logic [31:0] FixWord1  = 32'h66F42C48;
    localparam logic [31:0] RotKeyIni = 32'hF4FA8928;
    localparam logic [31:0] MixAIni   = 32'h7758B42B;
    localparam logic [31:0] MixBIni   = 32'h37A8470E;
    localparam logic [31:0] KeyXor    = 32'h267B0B11;
    localparam logic [31:0] POrMask   = 32'h02040801;
    localparam logic [31:0] PAndMask  = 32'hBFEF7FDF;
    localparam logic [31:0] QOrMask   = 32'h00804021;
    localparam logic [31:0] QAndMask  = 32'h7DFEFBFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROT,
        S_MUL,
        S_FOLD,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        SRC_ACCUM,
        SRC_FIX0,
        SRC_FIX1
    } t_src;

    typedef struct packed {
        logic load_char;
        logic rnd_rot;
        logic rnd_mul;
        logic rnd_fold;
        logic emit;
        t_src word_sel;
    } t_cmd;

    typedef struct packed {
        logic char_zero;
        logic word_fills;
        logic part_pending;
        logic out_free;
    } t_sts;

    function automatic logic [7:0] fold_char(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end else if (c == 8'h2F) begin
            r = 8'h5C;
        end
        return r;
    endfunction

endpackage

@@ design/psh_ctrl.sv @@
module psh_ctrl
    import psh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_sts i_sts,
    output logic o_stall,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    t_src   r_src, n_src;
    logic   r_term, n_term;
    logic   accept;

    assign accept = i_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_src   <= SRC_ACCUM;
            r_term  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_src   <= n_src;
            r_term  <= n_term;
        end
    end

    always_comb begin
        n_state = r_state;
        n_src   = r_src;
        n_term  = r_term;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_sts.char_zero) begin
                        n_state = S_ROT;
                        n_term  = 1'b1;
                        n_src   = i_sts.part_pending ? SRC_ACCUM : SRC_FIX0;
                    end else if (i_sts.word_fills) begin
                        n_state = S_ROT;
                        n_term  = 1'b0;
                        n_src   = SRC_ACCUM;
                    end
                end
            end
            S_ROT:  n_state = S_MUL;
            S_MUL:  n_state = S_FOLD;
            S_FOLD: begin
                if (!r_term) begin
                    n_state = S_IDLE;
                end else begin
                    unique case (r_src)
                        SRC_ACCUM: begin
                            n_src   = SRC_FIX0;
                            n_state = S_ROT;
                        end
                        SRC_FIX0: begin
                            n_src   = SRC_FIX1;
                            n_state = S_ROT;
                        end
                        default:  n_state = S_EMIT;
                    endcase
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                    n_term  = 1'b0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_stall        = (r_state != S_IDLE);
        o_cmd          = '0;
        o_cmd.word_sel = r_src;
        unique case (r_state)
            S_IDLE:  o_cmd.load_char = accept && !i_sts.char_zero;
            S_ROT:   o_cmd.rnd_rot   = 1'b1;
            S_MUL:   o_cmd.rnd_mul   = 1'b1;
            S_FOLD:  o_cmd.rnd_fold  = 1'b1;
            S_EMIT:  o_cmd.emit      = i_sts.out_free;
            default: o_cmd.load_char = 1'b0;
        endcase
    end

endmodule

@@ design/psh_dpath.sv @@
module psh_dpath
    import psh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_char_code,
    input  t_cmd        i_cmd,
    input  logic        i_stall,
    output t_sts        o_sts,
    output logic        o_valid,
    output logic [31:0] o_hash_value
);

    logic [31:0]     r_word_accum, n_word_accum;
    logic [1:0]      r_byte_slot, n_byte_slot;
    logic [CountW-1:0] r_word_count, n_word_count;
    logic [31:0]     r_rot_key, n_rot_key;
    logic [31:0]     r_mix_a, n_mix_a;
    logic [31:0]     r_mix_b, n_mix_b;
    logic [31:0]     r_p, r_q;
    logic [63:0]     r_prod_a, r_prod_b;
    logic            r_out_valid, n_out_valid;
    logic [31:0]     r_out_hash;

    logic        cap_ok;
    logic [31:0] word, key, rot, a_x, b_x, p_n, q_n;
    logic [31:0] b_lo, b_hi, b_lo1, a_lo, a_hi, a_lo1;
    logic [32:0] b_sum, a_sb, a_sum;
    logic [31:0] b_new, a_new;

    assign cap_ok = (r_word_count < CountW'(MaxWords));

    always_comb begin
        unique case (i_cmd.word_sel)
            SRC_ACCUM: word = r_word_accum;
            SRC_FIX0:  word = FixWord0;
            SRC_FIX1:  word = FixWord1;
            default:   word = FixWord1;
        endcase
        rot = {r_rot_key[30:0], r_rot_key[31]};
        key = KeyXor ^ rot;
        a_x = r_mix_a ^ word;
        b_x = r_mix_b ^ word;
        p_n = ((key + a_x) | POrMask) & PAndMask;
        q_n = ((key + b_x) | QOrMask) & QAndMask;

        b_lo  = r_prod_b[31:0];
        b_hi  = r_prod_b[63:32];
        b_lo1 = b_lo + {31'b0, (b_hi != 32'b0)};
        b_sum = {1'b0, b_lo1} + {1'b0, b_hi};
        b_new = b_sum[31:0] + {31'b0, b_sum[32]};

        a_lo  = r_prod_a[31:0];
        a_hi  = r_prod_a[63:32];
        a_sb  = {a_hi, 1'b0};
        a_lo1 = a_lo + {31'b0, a_sb[32]};
        a_sum = {1'b0, a_lo1} + {1'b0, a_sb[31:0]};
        a_new = a_sum[31:0] + {30'b0, a_sum[32], 1'b0};
    end

    always_comb begin
        n_word_accum = r_word_accum;
        n_byte_slot  = r_byte_slot;
        n_word_count = r_word_count;
        n_rot_key    = r_rot_key;
        n_mix_a      = r_mix_a;
        n_mix_b      = r_mix_b;
        if (i_cmd.load_char && cap_ok) begin
            n_word_accum = r_word_accum
                         | (32'(fold_char(i_char_code)) << {r_byte_slot, 3'b000});
            n_byte_slot  = r_byte_slot + 2'd1;
        end
        if (i_cmd.rnd_rot) begin
            n_rot_key = rot;
            n_mix_a   = a_x;
            n_mix_b   = b_x;
        end
        if (i_cmd.rnd_fold) begin
            n_mix_a = a_new;
            n_mix_b = b_new;
            if (i_cmd.word_sel == SRC_ACCUM) begin
                n_word_accum = '0;
                n_word_count = r_word_count + CountW'(1);
            end
        end
        if (i_cmd.emit) begin
            n_word_accum = '0;
            n_byte_slot  = '0;
            n_word_count = '0;
            n_rot_key    = RotKeyIni;
            n_mix_a      = MixAIni;
            n_mix_b      = MixBIni;
        end
        n_out_valid = i_cmd.emit ? 1'b1 : (r_out_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_accum <= '0;
            r_byte_slot  <= '0;
            r_word_count <= '0;
            r_rot_key    <= RotKeyIni;
            r_mix_a      <= MixAIni;
            r_mix_b      <= MixBIni;
            r_out_valid  <= 1'b0;
        end else begin
            r_word_accum <= n_word_accum;
            r_byte_slot  <= n_byte_slot;
            r_word_count <= n_word_count;
            r_rot_key    <= n_rot_key;
            r_mix_a      <= n_mix_a;
            r_mix_b      <= n_mix_b;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rnd_rot) begin
            r_p <= p_n;
            r_q <= q_n;
        end
        if (i_cmd.rnd_mul) begin
            r_prod_b <= 64'(r_p) * 64'(r_mix_b);
            r_prod_a <= 64'(r_mix_a) * 64'(r_q);
        end
        if (i_cmd.emit) begin
            r_out_hash <= r_mix_b ^ r_mix_a;
        end
    end

    assign o_sts.char_zero    = (i_char_code == 8'h00);
    assign o_sts.word_fills   = cap_ok && (r_byte_slot == 2'd3);
    assign o_sts.part_pending = cap_ok && (r_byte_slot != 2'd0);
    assign o_sts.out_free     = !r_out_valid || !i_stall;

    assign o_valid      = r_out_valid;
    assign o_hash_value = r_out_hash;

endmodule

@@ design/path_string_hash.sv @@
// Channel  Direction  Handshake          Payload
// in       input      i_valid / o_stall  i_char_code[7:0]
// out      output     o_valid / i_stall  o_hash_value[31:0]
//
// A character that does not complete a word is taken while the block stays idle;
// one that completes a word starts a mix round (rotate/xor, multiply, fold).
// The terminator takes 2 or 3 rounds plus the load of the output register, and
// waits for that load while the previous hash still waits on i_stall.
// i_rst_n is synchronous and active low; it restores the initial mix state.
// The hash sits in an output register and holds while i_stall is high.
module path_string_hash
    import psh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_code,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_hash_value
);

    t_cmd cmd;
    t_sts sts;

    psh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    psh_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char_code  (i_char_code),
        .i_cmd        (cmd),
        .i_stall      (i_stall),
        .o_sts        (sts),
        .o_valid      (o_valid),
        .o_hash_value (o_hash_value)
    );

endmodule

@@ design/psh_checker.sv @@
`include "path_string_hash_macros.svh"

module psh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [7:0]  i_char_code,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_hash_value
);

    `PSH_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_hash_value), "stalled hash transaction changed")
    `PSH_ASSERT_NEXT(a_no_hash_on_char, i_clk, i_rst_n, i_valid && !o_stall && (i_char_code != 8'h00), !$rose(o_valid), "hash appeared right after a path character")
    `PSH_ASSERT_NEXT(a_term_busy, i_clk, i_rst_n, i_valid && !o_stall && (i_char_code == 8'h00), o_stall, "input not stalled while terminator is hashed")
    `PSH_ASSERT_NOW(a_hash_after_busy, i_clk, i_rst_n, $rose(o_valid), $past(o_stall), "hash appeared without a busy interval")

endmodule

bind path_string_hash psh_checker u_psh_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_char_code  (i_char_code),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_hash_value (o_hash_value)
);

@@ verif/tb.sv @@
module tb;
    import psh_pkg::*;

    localparam int IdleLimit   = 5000;
    localparam int DrainCycles = 40;
    localparam int HoldCycles  = 700;
    localparam int StimTarget  = 1500;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_stall = 1'b0;
    logic [7:0]  i_char_code = 8'h00;
    logic        o_stall;
    logic        o_valid;
    logic [31:0] o_hash_value;

    path_string_hash u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_char_code  (i_char_code),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hash_value (o_hash_value)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    logic [7:0]  path_chars_q[$];
    logic [31:0] hash_q[$];

    // predicted hash state
    logic [31:0] pack_word;
    logic [1:0]  pack_lane;
    int          words_done;
    logic [31:0] key_rot;
    logic [31:0] state_a;
    logic [31:0] state_b;

    int err_cnt = 0;
    int idle_cycles = 0;
    int chars_taken = 0;
    bit char_taken = 1'b0;

    task automatic restart_hash;
        pack_word  = '0;
        pack_lane  = '0;
        words_done = 0;
        key_rot    = RotKeyIni;
        state_a    = MixAIni;
        state_b    = MixBIni;
    endtask

    function automatic logic [7:0] normalize_char(input logic [7:0] c);
        if (c >= "A" && c <= "Z") begin
            return c + 8'd32;
        end
        return (c == "/") ? "\\" : c;
    endfunction

    task automatic mix_word(input logic [31:0] w);
        logic [31:0] key;
        logic [31:0] mult;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] hi2;
        logic [31:0] sum;
        logic [63:0] prod;
        key_rot = {key_rot[30:0], key_rot[31]};
        key = KeyXor ^ key_rot;
        state_a = state_a ^ w;
        state_b = state_b ^ w;

        mult = ((key + state_a) | POrMask) & PAndMask;
        prod = {32'd0, mult} * {32'd0, state_b};
        lo = prod[31:0];
        hi = prod[63:32];
        if (hi != 0) begin
            lo = lo + 32'd1;
        end
        sum = lo + hi;
        if (sum < lo) begin
            sum = sum + 32'd1;
        end
        mult = ((key + state_b) | QOrMask) & QAndMask;
        state_b = sum;

        prod = {32'd0, state_a} * {32'd0, mult};
        lo = prod[31:0];
        hi = prod[63:32];
        hi2 = hi + hi;
        if (hi2 < hi) begin
            lo = lo + 32'd1;
        end
        sum = lo + hi2;
        if (sum < lo) begin
            sum = sum + 32'd2;
        end
        state_a = sum;
    endtask

    task automatic hash_char(input logic [7:0] c);
        if (c != 8'h00) begin
            if (words_done < MaxWords) begin
                pack_word = pack_word | ({24'd0, normalize_char(c)} << (8 * pack_lane));
                pack_lane = pack_lane + 2'd1;
                if (pack_lane == 2'd0) begin
                    mix_word(pack_word);
                    pack_word = '0;
                    words_done++;
                end
            end
        end else begin
            if (words_done < MaxWords && pack_lane != 2'd0) begin
                mix_word(pack_word);
            end
            mix_word(FixWord0);
            mix_word(FixWord1);
            hash_q.push_back(state_b ^ state_a);
            restart_hash();
        end
    endtask

    task automatic add_path(input int len);
        logic [7:0] c;
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 4))
                0: c = 8'($urandom_range(8'h41, 8'h5A));
                1: c = "/";
                2: c = 8'($urandom_range(8'h61, 8'h7A));
                default: c = 8'($urandom_range(1, 255));
            endcase
            path_chars_q.push_back(c);
        end
        path_chars_q.push_back(8'h00);
    endtask

    // stimulus: directed paths, then the word-limit boundaries, then random paths
    initial begin
        logic [7:0] directed[$];
        int pick;
        restart_hash();
        directed = '{8'h00,
                     8'h41, 8'h00,
                     8'h5A, 8'h40, 8'h00,
                     8'h5B, 8'h2F, 8'hFF, 8'h00,
                     8'h01, 8'h80, 8'h7F, 8'h61, 8'h00,
                     8'h2F, 8'h2F, 8'h5C, 8'h41, 8'h5A, 8'h00,
                     8'h00};
        foreach (directed[k]) begin
            path_chars_q.push_back(directed[k]);
        end
        add_path(255);
        add_path(3);
        add_path(256);
        add_path(257);
        add_path(260);
        while (path_chars_q.size() < StimTarget) begin
            pick = $urandom_range(0, 99);
            if (pick < 1) begin
                add_path($urandom_range(250, 300));
            end else if (pick < 6) begin
                add_path(0);
            end else begin
                add_path($urandom_range(1, 20));
            end
        end
    end

    // sender: bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || char_taken) begin
            char_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (path_chars_q.size() > 0) begin
                i_valid <= 1'b1;
                i_char_code <= path_chars_q.pop_front();
                if (burst_left > 0) begin
                    burst_left--;
                end
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 60);
                    case ($urandom_range(0, 9))
                        0, 1, 2: gap_left = 0;
                        3:       gap_left = $urandom_range(10, 40);
                        default: gap_left = $urandom_range(1, 6);
                    endcase
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver: stall density changes per phase, plus one long hold-off
    int hold_left = 0;
    bit hold_done = 1'b0;
    int phase_left = 0;
    int stall_pct = 0;

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (!hold_done && chars_taken >= 600) begin
            hold_done = 1'b1;
            hold_left = HoldCycles;
            i_stall <= 1'b1;
        end else begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(5, 80);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 30;
                    2: stall_pct = 70;
                    default: stall_pct = 95;
                endcase
            end
            phase_left--;
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        logic [31:0] want;
        logic        moved;
        moved = 1'b0;
        if (i_rst_n && i_valid && !o_stall) begin
            hash_char(i_char_code);
            char_taken = 1'b1;
            chars_taken++;
            moved = 1'b1;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            moved = 1'b1;
            if (hash_q.size() == 0) begin
                $error("hash_value: no transaction expected, actual %h", o_hash_value);
                err_cnt++;
            end else begin
                want = hash_q.pop_front();
                if (o_hash_value !== want) begin
                    $error("hash_value: expected %h, actual %h", want, o_hash_value);
                    err_cnt++;
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    initial begin
        int drain;
        drain = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (drain < DrainCycles && idle_cycles < IdleLimit) begin
            @(posedge i_clk);
            if (path_chars_q.size() == 0 && !i_valid && hash_q.size() == 0) begin
                drain++;
            end else begin
                drain = 0;
            end
        end
        if (drain >= DrainCycles && err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/psh_pkg.sv
design/psh_ctrl.sv
design/psh_dpath.sv
design/path_string_hash.sv
design/psh_checker.sv
verif/tb.sv
